>>> hdl/pbl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbl_pkg
// shared types and codes of the palette pixel blend unit
// ----------------------------------------------------------------------------
package pbl_pkg;

   // item opcodes
   typedef enum logic [0:0] {
      OP_LOAD  = 1'b0,
      OP_BLEND = 1'b1
   } pbl_op_type;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } pbl_csr_type;

   localparam int unsigned INDEX_BITS = 8;
   localparam logic [7:0]  ALPHA_MAX  = 8'd255;

   // bytes r,g,b,a from the low end
   typedef struct packed {
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] g;
      logic [7:0] r;
   } pbl_pixel_type;

   // lookup stage to multiply stage
   typedef struct packed {
      logic valid;
      logic in_frame;
   } pbl_lkp_ctl_type;

   // multiply stage to divide stage
   typedef struct packed {
      logic valid;
      logic in_frame;
      logic blend;
   } pbl_mul_ctl_type;

endpackage
`default_nettype wire

>>> hdl/pbl_lookup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbl_lookup
// palette memory, load writes, registered color read and position clipping
// ----------------------------------------------------------------------------
module pbl_lookup #(
   parameter int PALETTE_DEPTH = 256,
   parameter int COORD_BITS    = 13
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_op,
   input  wire logic [pbl_pkg::INDEX_BITS-1:0] req_pal_index,
   input  wire logic [31:0]                  req_pal_entry,
   input  wire logic signed [COORD_BITS:0]   req_pos_x,
   input  wire logic signed [COORD_BITS:0]   req_pos_y,
   input  wire logic [31:0]                  req_dst_pixel,
   input  wire logic [COORD_BITS-1:0]        frame_width,
   input  wire logic [COORD_BITS-1:0]        frame_height,
   output pbl_pkg::pbl_lkp_ctl_type          lkp_ctl,
   input  wire logic                         lkp_ready,
   output pbl_pkg::pbl_pixel_type            lkp_color,
   output pbl_pkg::pbl_pixel_type            lkp_dst,
   output logic [COORD_BITS-1:0]             lkp_x,
   output logic [COORD_BITS-1:0]             lkp_y
);
   import pbl_pkg::*;

   localparam int ADDR_BITS = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam logic [INDEX_BITS:0] DEPTH_LIMIT = (INDEX_BITS + 1)'(PALETTE_DEPTH);

   logic [31:0]           mem [PALETTE_DEPTH];
   logic [31:0]           rd_ff;
   logic                  in_range_ff;
   logic                  valid_ff;
   logic                  inside_ff;
   logic [31:0]           dst_ff;
   logic [COORD_BITS-1:0] x_ff;
   logic [COORD_BITS-1:0] y_ff;

   logic                  accept;
   logic                  in_range;
   logic                  inside_in;
   logic [ADDR_BITS-1:0]  addr;

   assign req_ready = !valid_ff || lkp_ready;
   assign accept    = req_valid && req_ready;
   assign in_range  = {1'b0, req_pal_index} < DEPTH_LIMIT;
   assign addr      = req_pal_index[ADDR_BITS-1:0];

   assign inside_in = !req_pos_x[COORD_BITS] && !req_pos_y[COORD_BITS]
                      && (req_pos_x[COORD_BITS-1:0] < frame_width)
                      && (req_pos_y[COORD_BITS-1:0] < frame_height);

   // palette write on load beats, registered read on blend beats
   always_ff @(posedge clock) begin
      if (accept && (req_op == OP_LOAD) && in_range) begin
         mem[addr] <= req_pal_entry;
      end
      if (accept && (req_op == OP_BLEND) && in_range) begin
         rd_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= accept && (req_op == OP_BLEND);
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_range_ff <= in_range;
         inside_ff   <= inside_in;
         dst_ff      <= req_dst_pixel;
         x_ff        <= req_pos_x[COORD_BITS-1:0];
         y_ff        <= req_pos_y[COORD_BITS-1:0];
      end
   end

   assign lkp_ctl.valid    = valid_ff;
   assign lkp_ctl.in_frame = inside_ff;
   assign lkp_color        = in_range_ff ? pbl_pixel_type'(rd_ff) : pbl_pixel_type'(32'd0);
   assign lkp_dst          = pbl_pixel_type'(dst_ff);
   assign lkp_x            = x_ff;
   assign lkp_y            = y_ff;

endmodule
`default_nettype wire

>>> hdl/pbl_mult.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbl_mult
// per-channel weighted sums of source and destination bytes
// ----------------------------------------------------------------------------
module pbl_mult #(
   parameter int COORD_BITS = 13
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  pbl_pkg::pbl_lkp_ctl_type   lkp_ctl,
   output logic                       lkp_ready,
   input  pbl_pkg::pbl_pixel_type     lkp_color,
   input  pbl_pkg::pbl_pixel_type     lkp_dst,
   input  wire logic [COORD_BITS-1:0] lkp_x,
   input  wire logic [COORD_BITS-1:0] lkp_y,
   output pbl_pkg::pbl_mul_ctl_type   mul_ctl,
   input  wire logic                  mul_ready,
   output logic [15:0]                mul_sum_r,
   output logic [15:0]                mul_sum_g,
   output logic [15:0]                mul_sum_b,
   output logic [15:0]                mul_prod_a,
   output logic [7:0]                 mul_alpha,
   output pbl_pkg::pbl_pixel_type     mul_dst,
   output logic [COORD_BITS-1:0]      mul_x,
   output logic [COORD_BITS-1:0]      mul_y
);
   import pbl_pkg::*;

   logic                  valid_ff;
   logic                  inside_ff;
   logic                  blend_ff;
   logic [15:0]           sum_r_ff;
   logic [15:0]           sum_g_ff;
   logic [15:0]           sum_b_ff;
   logic [15:0]           prod_a_ff;
   logic [7:0]            alpha_ff;
   pbl_pixel_type         dst_ff;
   logic [COORD_BITS-1:0] x_ff;
   logic [COORD_BITS-1:0] y_ff;

   logic [7:0]            inv;

   assign lkp_ready = !valid_ff || mul_ready;
   assign inv       = ALPHA_MAX - lkp_color.a;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (lkp_ready) begin
         valid_ff <= lkp_ctl.valid;
      end
   end

   // sums never exceed 255 * 255, so 16 bits hold them
   always_ff @(posedge clock) begin
      if (lkp_ready) begin
         inside_ff <= lkp_ctl.in_frame;
         blend_ff  <= lkp_ctl.in_frame && (lkp_color.a != 8'd0);
         sum_r_ff  <= 16'(lkp_color.r * lkp_color.a) + 16'(lkp_dst.r * inv);
         sum_g_ff  <= 16'(lkp_color.g * lkp_color.a) + 16'(lkp_dst.g * inv);
         sum_b_ff  <= 16'(lkp_color.b * lkp_color.a) + 16'(lkp_dst.b * inv);
         prod_a_ff <= 16'(lkp_dst.a * inv);
         alpha_ff  <= lkp_color.a;
         dst_ff    <= lkp_dst;
         x_ff      <= lkp_x;
         y_ff      <= lkp_y;
      end
   end

   assign mul_ctl.valid    = valid_ff;
   assign mul_ctl.in_frame = inside_ff;
   assign mul_ctl.blend    = blend_ff;
   assign mul_sum_r        = sum_r_ff;
   assign mul_sum_g        = sum_g_ff;
   assign mul_sum_b        = sum_b_ff;
   assign mul_prod_a       = prod_a_ff;
   assign mul_alpha        = alpha_ff;
   assign mul_dst          = dst_ff;
   assign mul_x            = x_ff;
   assign mul_y            = y_ff;

endmodule
`default_nettype wire

>>> hdl/pbl_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbl_div
// division by 255, result assembly and output register
// ----------------------------------------------------------------------------
module pbl_div #(
   parameter int COORD_BITS = 13
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  pbl_pkg::pbl_mul_ctl_type   mul_ctl,
   output logic                       mul_ready,
   input  wire logic [15:0]           mul_sum_r,
   input  wire logic [15:0]           mul_sum_g,
   input  wire logic [15:0]           mul_sum_b,
   input  wire logic [15:0]           mul_prod_a,
   input  wire logic [7:0]            mul_alpha,
   input  pbl_pkg::pbl_pixel_type     mul_dst,
   input  wire logic [COORD_BITS-1:0] mul_x,
   input  wire logic [COORD_BITS-1:0] mul_y,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_write_enable,
   output logic [COORD_BITS-1:0]      rsp_out_x,
   output logic [COORD_BITS-1:0]      rsp_out_y,
   output logic [31:0]                rsp_out_pixel
);
   import pbl_pkg::*;

   // v / 255 for v up to 255 * 255: estimate by v * 257 / 65536, then one correction
   function automatic logic [7:0] div255(input logic [15:0] v);
      logic [23:0] scaled;
      logic [15:0] q0;
      logic [15:0] rem;
      scaled = {v, 8'd0} + {8'd0, v};
      q0     = {8'd0, scaled[23:16]};
      rem    = v - ({q0[7:0], 8'd0} - q0);
      return (rem >= 16'd255) ? (q0[7:0] + 8'd1) : q0[7:0];
   endfunction

   logic                  valid_ff;
   logic                  we_ff;
   logic [COORD_BITS-1:0] x_ff;
   logic [COORD_BITS-1:0] y_ff;
   pbl_pixel_type         pixel_ff;

   pbl_pixel_type         blended;

   assign mul_ready = !valid_ff || rsp_ready;

   always_comb begin
      blended.r = div255(mul_sum_r);
      blended.g = div255(mul_sum_g);
      blended.b = div255(mul_sum_b);
      blended.a = mul_alpha + div255(mul_prod_a);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (mul_ready) begin
         valid_ff <= mul_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_ready) begin
         we_ff    <= mul_ctl.blend;
         x_ff     <= mul_ctl.in_frame ? mul_x : '0;
         y_ff     <= mul_ctl.in_frame ? mul_y : '0;
         pixel_ff <= mul_ctl.blend ? blended : mul_dst;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_write_enable = we_ff;
   assign rsp_out_x        = x_ff;
   assign rsp_out_y        = y_ff;
   assign rsp_out_pixel    = pixel_ff;

endmodule
`default_nettype wire

>>> hdl/palette_pixel_src_over_blend_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// palette_pixel_src_over_blend_unit
// palette lookup and source-over compositing of subtitle pixels onto a canvas
// ----------------------------------------------------------------------------
//  channel  direction  beat
//  req_     in         op, palette index, palette word, position, canvas pixel
//  rsp_     out        write enable, canvas column and row, blended pixel
//  csr_     in         register index, write data (frame width, frame height)
//
//  one beat per cycle in both directions while rsp_ready holds; req_ to rsp_ passes
//  the stage registers of palette read and clip, channel products, divide by 255
//  load beats write the palette and give no rsp_ beat
//  reset clears the frame size and the stage valid bits; palette has no reset
//  each stage takes a beat when it is empty or its successor takes its beat,
//  so a stalled rsp_ beat holds and the stages behind it keep filling
// ----------------------------------------------------------------------------
module palette_pixel_src_over_blend_unit #(
   parameter int PALETTE_DEPTH = 256,
   parameter int COORD_BITS    = 13
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_op,
   input  wire logic [pbl_pkg::INDEX_BITS-1:0] req_pal_index,
   input  wire logic [31:0]                  req_pal_entry,
   input  wire logic signed [COORD_BITS:0]   req_pos_x,
   input  wire logic signed [COORD_BITS:0]   req_pos_y,
   input  wire logic [31:0]                  req_dst_pixel,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_write_enable,
   output logic [COORD_BITS-1:0]             rsp_out_x,
   output logic [COORD_BITS-1:0]             rsp_out_y,
   output logic [31:0]                       rsp_out_pixel,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic                         csr_index,
   input  wire logic [COORD_BITS-1:0]        csr_wdata
);
   import pbl_pkg::*;

   // frame size registers
   logic [COORD_BITS-1:0] frame_width_ff;
   logic [COORD_BITS-1:0] frame_height_ff;

   // stage links
   pbl_lkp_ctl_type       lkp_ctl;
   logic                  lkp_ready;
   pbl_pixel_type         lkp_color;
   pbl_pixel_type         lkp_dst;
   logic [COORD_BITS-1:0] lkp_x;
   logic [COORD_BITS-1:0] lkp_y;

   pbl_mul_ctl_type       mul_ctl;
   logic                  mul_ready;
   logic [15:0]           mul_sum_r;
   logic [15:0]           mul_sum_g;
   logic [15:0]           mul_sum_b;
   logic [15:0]           mul_prod_a;
   logic [7:0]            mul_alpha;
   pbl_pixel_type         mul_dst;
   logic [COORD_BITS-1:0] mul_x;
   logic [COORD_BITS-1:0] mul_y;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= '0;
         frame_height_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (pbl_csr_type'(csr_index))
            CSR_FRAME_WIDTH: begin
               frame_width_ff <= csr_wdata;
            end
            CSR_FRAME_HEIGHT: begin
               frame_height_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // stage 1: palette memory and clip test
   pbl_lookup #(
      .PALETTE_DEPTH (PALETTE_DEPTH),
      .COORD_BITS    (COORD_BITS)
   ) u_lookup (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_pal_index (req_pal_index),
      .req_pal_entry (req_pal_entry),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_dst_pixel (req_dst_pixel),
      .frame_width   (frame_width_ff),
      .frame_height  (frame_height_ff),
      .lkp_ctl       (lkp_ctl),
      .lkp_ready     (lkp_ready),
      .lkp_color     (lkp_color),
      .lkp_dst       (lkp_dst),
      .lkp_x         (lkp_x),
      .lkp_y         (lkp_y)
   );

   // stage 2: c*a + d*(255-a) per color channel, d*(255-a) for alpha
   pbl_mult #(
      .COORD_BITS (COORD_BITS)
   ) u_mult (
      .clock      (clock),
      .reset      (reset),
      .lkp_ctl    (lkp_ctl),
      .lkp_ready  (lkp_ready),
      .lkp_color  (lkp_color),
      .lkp_dst    (lkp_dst),
      .lkp_x      (lkp_x),
      .lkp_y      (lkp_y),
      .mul_ctl    (mul_ctl),
      .mul_ready  (mul_ready),
      .mul_sum_r  (mul_sum_r),
      .mul_sum_g  (mul_sum_g),
      .mul_sum_b  (mul_sum_b),
      .mul_prod_a (mul_prod_a),
      .mul_alpha  (mul_alpha),
      .mul_dst    (mul_dst),
      .mul_x      (mul_x),
      .mul_y      (mul_y)
   );

   // stage 3: divide by 255 into the output register
   pbl_div #(
      .COORD_BITS (COORD_BITS)
   ) u_div (
      .clock            (clock),
      .reset            (reset),
      .mul_ctl          (mul_ctl),
      .mul_ready        (mul_ready),
      .mul_sum_r        (mul_sum_r),
      .mul_sum_g        (mul_sum_g),
      .mul_sum_b        (mul_sum_b),
      .mul_prod_a       (mul_prod_a),
      .mul_alpha        (mul_alpha),
      .mul_dst          (mul_dst),
      .mul_x            (mul_x),
      .mul_y            (mul_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_write_enable (rsp_write_enable),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_out_pixel    (rsp_out_pixel)
   );

endmodule
`default_nettype wire

>>> sim/pbl_blend_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbl_blend_checker
// follows palette loads and frame size writes, computes the canvas write
// expected for every blend beat and compares it with the rsp_ channel
// ----------------------------------------------------------------------------
module pbl_blend_checker #(
   parameter int PALETTE_DEPTH = 256,
   parameter int COORD_BITS    = 13
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic                         req_op,
   input  logic [7:0]                   req_pal_index,
   input  logic [31:0]                  req_pal_entry,
   input  logic signed [COORD_BITS:0]   req_pos_x,
   input  logic signed [COORD_BITS:0]   req_pos_y,
   input  logic [31:0]                  req_dst_pixel,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic                         rsp_write_enable,
   input  logic [COORD_BITS-1:0]        rsp_out_x,
   input  logic [COORD_BITS-1:0]        rsp_out_y,
   input  logic [31:0]                  rsp_out_pixel,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic                         csr_index,
   input  logic [COORD_BITS-1:0]        csr_wdata,
   output int                           outstanding,
   output int                           mismatch_count
);

   typedef struct packed {
      logic                  we;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [31:0]           pixel;
   } canvas_write_type;

   logic [31:0]           clut [PALETTE_DEPTH];
   logic [COORD_BITS-1:0] frame_w = '0;
   logic [COORD_BITS-1:0] frame_h = '0;
   canvas_write_type      pending_writes [$];
   int                    mismatches = 0;

   task automatic report_mismatch(input string msg);
      $display("%0t ns: blend check: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s mismatch, got %h expected %h", name, got, want));
   endtask

   // source-over of the palette color onto the canvas pixel, truncating
   function automatic canvas_write_type composite_pixel(input logic [7:0] idx,
                                                        input logic signed [COORD_BITS:0] px,
                                                        input logic signed [COORD_BITS:0] py,
                                                        input logic [31:0] dst);
      pbl_pkg::pbl_pixel_type src, under, mixed;
      int unsigned            a, inv, full;
      int                     xi, yi;
      canvas_write_type       w;
      src   = (idx < PALETTE_DEPTH) ? clut[idx] : 32'h0;
      under = dst;
      full  = 32'(pbl_pkg::ALPHA_MAX);
      a     = 32'(src.a);
      inv   = full - a;
      xi    = int'(px);
      yi    = int'(py);
      w.we    = 1'b0;
      w.x     = '0;
      w.y     = '0;
      w.pixel = dst;
      if (xi >= 0 && yi >= 0 && xi < int'(frame_w) && yi < int'(frame_h)) begin
         w.x = px[COORD_BITS-1:0];
         w.y = py[COORD_BITS-1:0];
         if (a != 0) begin
            mixed.r = 8'((src.r * a + under.r * inv) / full);
            mixed.g = 8'((src.g * a + under.g * inv) / full);
            mixed.b = 8'((src.b * a + under.b * inv) / full);
            mixed.a = 8'(a + under.a * inv / full);
            w.we    = 1'b1;
            w.pixel = mixed;
         end
      end
      return w;
   endfunction

   always @(posedge clock) begin
      canvas_write_type want;
      if (reset) begin
         frame_w = '0;
         frame_h = '0;
         pending_writes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == pbl_pkg::CSR_FRAME_WIDTH)
               frame_w = csr_wdata;
            else
               frame_h = csr_wdata;
         end
         if (req_valid && req_ready) begin
            if (req_op == pbl_pkg::OP_LOAD) begin
               if (req_pal_index < PALETTE_DEPTH)
                  clut[req_pal_index] = req_pal_entry;
            end else begin
               pending_writes.push_back(composite_pixel(req_pal_index, req_pos_x,
                                                        req_pos_y, req_dst_pixel));
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_writes.size() == 0) begin
               report_mismatch($sformatf("rsp beat with no blend outstanding, pixel %h",
                                         rsp_out_pixel));
            end else begin
               want = pending_writes.pop_front();
               check_field("write_enable", 32'(rsp_write_enable), 32'(want.we));
               check_field("out_x", 32'(rsp_out_x), 32'(want.x));
               check_field("out_y", 32'(rsp_out_y), 32'(want.y));
               check_field("out_pixel", rsp_out_pixel, want.pixel);
            end
         end
      end
      outstanding    <= pending_writes.size();
      mismatch_count <= mismatches;
   end

endmodule

>>> sim/tb_palette_pixel_src_over_blend_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_palette_pixel_src_over_blend_unit
// stimulus for the palette blend unit: directed corner beats, then random
// palette loads and blends over a series of frame sizes with random idling
// on both channels; the checker beside the unit predicts every canvas write
// ----------------------------------------------------------------------------
module tb_palette_pixel_src_over_blend_unit;
   import pbl_pkg::*;

   localparam int COORD_BITS    = 13;
   localparam int PIPE_LATENCY  = 3;        // req_ to rsp_, through the stage registers of the unit
   localparam int TIMEOUT_NS    = 400000;   // far beyond the slowest passing run
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_BEATS   = 107;

   // frame sizes of the random phases: typical, extremes, zero and one
   localparam int PHASE_W [RANDOM_PHASES] = '{640, 8191, 64,  0, 1920, 8191,    3, 1};
   localparam int PHASE_H [RANDOM_PHASES] = '{480,    1, 48, 100, 1080, 8191, 8191, 1};

   logic                        clock            = 1'b0;
   logic                        reset            = 1'b1;
   logic                        req_valid        = 1'b0;
   logic                        req_ready;
   pbl_op_type                  req_op           = OP_LOAD;
   logic [7:0]                  req_pal_index    = '0;
   logic [31:0]                 req_pal_entry    = '0;
   logic signed [COORD_BITS:0]  req_pos_x        = '0;
   logic signed [COORD_BITS:0]  req_pos_y        = '0;
   logic [31:0]                 req_dst_pixel    = '0;
   logic                        rsp_valid;
   logic                        rsp_ready        = 1'b0;
   logic                        rsp_write_enable;
   logic [COORD_BITS-1:0]       rsp_out_x;
   logic [COORD_BITS-1:0]       rsp_out_y;
   logic [31:0]                 rsp_out_pixel;
   logic                        csr_valid        = 1'b0;
   logic                        csr_ready;
   pbl_csr_type                 csr_index        = CSR_FRAME_WIDTH;
   logic [COORD_BITS-1:0]       csr_wdata        = '0;

   int                          outstanding;
   int                          mismatch_count;

   // no idling on either side while set
   bit                          no_gaps = 1'b0;

   // palette entries written so far, blends only ever look these up
   bit                          clut_loaded [256];
   logic [7:0]                  loaded_idx [$];

   // frame size currently programmed, steers the random positions
   logic [COORD_BITS-1:0]       cur_w = '0;
   logic [COORD_BITS-1:0]       cur_h = '0;

   palette_pixel_src_over_blend_unit #(
      .PALETTE_DEPTH (256),
      .COORD_BITS    (COORD_BITS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_pal_index    (req_pal_index),
      .req_pal_entry    (req_pal_entry),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_dst_pixel    (req_dst_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_write_enable (rsp_write_enable),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_out_pixel    (rsp_out_pixel),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   pbl_blend_checker #(
      .PALETTE_DEPTH (256),
      .COORD_BITS    (COORD_BITS)
   ) u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_pal_index    (req_pal_index),
      .req_pal_entry    (req_pal_entry),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_dst_pixel    (req_dst_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_write_enable (rsp_write_enable),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_out_pixel    (rsp_out_pixel),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .outstanding      (outstanding),
      .mismatch_count   (mismatch_count)
   );

   always #1 clock = ~clock;

   // result side backpressure: ready drops with a chance of about 16 in a hundred
   always @(posedge clock) begin
      rsp_ready <= no_gaps || ($urandom_range(99) >= 16);
   end

   // one req_ beat; valid stays up on return so back-to-back beats keep it high
   // an idle gap before about 8 beats in a hundred unless no_gaps is set
   task automatic push_beat(input pbl_op_type op, input logic [7:0] idx,
                            input logic [31:0] entry,
                            input logic signed [COORD_BITS:0] x,
                            input logic signed [COORD_BITS:0] y,
                            input logic [31:0] dst);
      if (!no_gaps && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_pal_index <= idx;
      req_pal_entry <= entry;
      req_pos_x     <= x;
      req_pos_y     <= y;
      req_dst_pixel <= dst;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // palette load, position and canvas fields carry noise
   task automatic send_load(input logic [7:0] idx, input logic [31:0] entry);
      if (!clut_loaded[idx]) begin
         clut_loaded[idx] = 1'b1;
         loaded_idx.push_back(idx);
      end
      push_beat(OP_LOAD, idx, entry, (COORD_BITS + 1)'($urandom()),
                (COORD_BITS + 1)'($urandom()), $urandom());
   endtask

   // blend beat, palette word field carries noise
   task automatic send_blend(input logic [7:0] idx, input logic signed [COORD_BITS:0] x,
                             input logic signed [COORD_BITS:0] y, input logic [31:0] dst);
      push_beat(OP_BLEND, idx, $urandom(), x, y, dst);
   endtask

   // sender pauses until every blend has come back, then lets loads drain
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   // both frame size registers back to back while the unit is idle
   task automatic set_frame(input logic [COORD_BITS-1:0] w, input logic [COORD_BITS-1:0] h);
      settle();
      csr_valid <= 1'b1;
      csr_index <= CSR_FRAME_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_FRAME_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_w = w;
      cur_h = h;
   endtask

   // mostly inside the frame, with edges, -1 and the full signed range mixed in
   function automatic logic signed [COORD_BITS:0] pick_coord(input int lim);
      logic signed [COORD_BITS:0] c;
      c = (COORD_BITS + 1)'($urandom());
      case ($urandom_range(9))
         0: ;
         1: c = (COORD_BITS + 1)'(lim);       // first column or row past the edge
         2: c = (COORD_BITS + 1)'(lim - 1);   // last one inside, -1 for an empty frame
         3: c = '1;
         default: if (lim > 0) c = (COORD_BITS + 1)'($urandom_range(lim - 1));
      endcase
      return c;
   endfunction

   initial begin
      logic [7:0] alpha;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // palette corners: transparent, opaque white and black, alpha one, half and 254
      send_load(8'd0,   32'h00FF_FFFF);
      send_load(8'd255, 32'hFFFF_FFFF);
      send_load(8'd1,   32'hFF00_0000);
      send_load(8'd2,   32'h01FF_80FF);
      send_load(8'd3,   32'h8040_C020);
      send_load(8'd128, 32'hFE12_3456);

      // frame size still zero after reset, everything is clipped
      send_blend(8'd255, 14'sd0, 14'sd0, 32'h1234_5678);
      send_blend(8'd3,   14'sd5, 14'sd5, 32'hFFFF_FFFF);

      // largest frame
      set_frame(13'd8191, 13'd8191);
      send_blend(8'd255, 14'sd0,    14'sd0,    32'h0000_0000);
      send_blend(8'd1,   14'sd8190, 14'sd8190, 32'hFFFF_FFFF);
      send_blend(8'd255, 14'sd8191, 14'sd10,   32'hA5A5_A5A5);  // x one past the edge
      send_blend(8'd255, 14'sh2000, 14'sd0,    32'h5A5A_5A5A);  // most negative x
      send_blend(8'd255, 14'sd0,    14'sh2000, 32'h0F0F_0F0F);  // most negative y
      send_blend(8'd3,   -14'sd1,   -14'sd1,   32'hF0F0_F0F0);
      send_blend(8'd0,   14'sd100,  14'sd200,  32'h8877_6655);  // zero source alpha
      send_blend(8'd2,   14'sd1,    14'sd1,    32'hFFFF_FFFF);  // alpha of one
      send_blend(8'd3,   14'sd4095, 14'sd4095, 32'h0000_0000);
      send_blend(8'd128, 14'sd17,   14'sd9,    32'h8080_8080);

      // single pixel frame
      set_frame(13'd1, 13'd1);
      send_blend(8'd255, 14'sd0, 14'sd0, 32'h0102_0304);
      send_blend(8'd255, 14'sd1, 14'sd0, 32'h0102_0304);
      send_blend(8'd255, 14'sd0, 14'sd1, 32'h0102_0304);

      // random phases, one frame size each
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_frame(COORD_BITS'(PHASE_W[p]), COORD_BITS'(PHASE_H[p]));
         no_gaps = (p == 2);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            // one mid-stream pause until the pipe is empty
            if (p == 4 && n == PHASE_BEATS / 2)
               settle();
            if (loaded_idx.size() == 0 || $urandom_range(3) == 0) begin
               case ($urandom_range(3))
                  0:       alpha = 8'h00;
                  1:       alpha = 8'hFF;
                  default: alpha = 8'($urandom());
               endcase
               send_load(8'($urandom()), {alpha, 24'($urandom())});
            end else begin
               send_blend(loaded_idx[$urandom_range(loaded_idx.size() - 1)],
                          pick_coord(int'(cur_w)), pick_coord(int'(cur_h)), $urandom());
            end
         end
      end
      no_gaps = 1'b0;

      // wait out the last blends, then give the verdict
      settle();
      if (mismatch_count == 0 && outstanding == 0)
         $display("tb_palette_pixel_src_over_blend_unit: PASS");
      else
         $display("tb_palette_pixel_src_over_blend_unit: FAIL");
      $finish;
   end

   // hung handshake guard
   initial begin
      #(TIMEOUT_NS);
      $display("tb_palette_pixel_src_over_blend_unit: FAIL");
      $finish;
   end

endmodule
